// ===== hdl/splc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// splc_pkg: shared types and constants for the sector point locator
// Item codes, status codes, controller states and stream field layout.
// ----------------------------------------------------------------------------
package splc_pkg;

    // input transfer layout (s_tdata, lowest bit first)
    localparam int FIELD_BITS    = 24;
    localparam int HGT_BITS      = 16;
    localparam int POS_A_LSB     = 0;
    localparam int POS_B_LSB     = 24;
    localparam int QH_LSB        = 48;
    localparam int FLOOR_LSB     = 72;
    localparam int CEIL_LSB      = 88;
    localparam int IN_DATA_BITS  = 104;
    localparam int ACT_BITS      = 2;

    // result transfer layout
    localparam int INDEX_BITS    = 6;
    localparam int STATUS_BITS   = 2;
    localparam int OUT_DATA_BITS = 8;
    localparam int OUT_USER_BITS = 3;
    localparam int FOUND_BIT     = 2;

    typedef enum logic [1:0] {
        ACT_BEGIN  = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_LOCATE = 2'd2,
        ACT_NOP    = 2'd3
    } act_t;

    typedef enum logic [1:0] {
        STS_OK          = 2'd0,
        STS_SECTOR_FULL = 2'd1,
        STS_VERTEX_FULL = 2'd2,
        STS_NO_SECTOR   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SREQ,
        ST_SCHK,
        ST_VRUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // vertex read tag, travels with the registered memory read
    typedef struct packed {
        logic vld;
        logic first;
    } vtx_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/splc_edge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// splc_edge: even-odd crossing pipeline
// Takes one vertex per cycle, pairs it with the previous one and toggles the
// parity on each wall the horizontal ray crosses. Exact cross-multiplied test.
// ----------------------------------------------------------------------------
module splc_edge #(
    parameter int COORD_BITS = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         clear,
    input  splc_pkg::vtx_ctl_t           vin,
    input  logic signed [COORD_BITS-1:0] va,
    input  logic signed [COORD_BITS-1:0] vb,
    input  logic signed [COORD_BITS-1:0] qa,
    input  logic signed [COORD_BITS-1:0] qb,
    output logic                         busy,
    output logic                         parity
);
    import splc_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic signed [COORD_BITS-1:0] prev_a_reg, prev_b_reg;

    logic                 s1_vld_reg, s1_vld_next;
    logic                 s1_cross_reg, s1_cross_next;
    logic                 s1_dypos_reg, s1_dypos_next;
    logic signed [DW-1:0] s1_da_reg, s1_da_next;
    logic signed [DW-1:0] s1_dy_reg, s1_dy_next;
    logic signed [DW-1:0] s1_dx_reg, s1_dx_next;
    logic signed [DW-1:0] s1_db_reg, s1_db_next;

    logic                 s2_vld_reg, s2_vld_next;
    logic                 s2_cross_reg;
    logic                 s2_dypos_reg;
    logic signed [PW-1:0] s2_lhs_reg, s2_lhs_next;
    logic signed [PW-1:0] s2_rhs_reg, s2_rhs_next;

    logic parity_reg, parity_next;
    logic flip;

    // stage 1: straddle test and differences (cur = incoming, prev = held)
    always_comb begin
        s1_vld_next   = vin.vld && !vin.first;
        s1_cross_next = (vb > qb) != (prev_b_reg > qb);
        s1_dy_next    = DW'(prev_b_reg) - DW'(vb);
        s1_da_next    = DW'(qa) - DW'(va);
        s1_dx_next    = DW'(prev_a_reg) - DW'(va);
        s1_db_next    = DW'(qb) - DW'(vb);
        s1_dypos_next = s1_dy_next > 0;
    end

    // stage 2: the two products
    always_comb begin
        s2_vld_next = s1_vld_reg;
        s2_lhs_next = PW'(s1_da_reg) * PW'(s1_dy_reg);
        s2_rhs_next = PW'(s1_dx_reg) * PW'(s1_db_reg);
    end

    // stage 3: compare with the sign of dy
    always_comb begin
        flip = s2_cross_reg &&
               (s2_dypos_reg ? (s2_lhs_reg < s2_rhs_reg) : (s2_lhs_reg > s2_rhs_reg));
        if (clear) begin
            parity_next = 1'b0;
        end else begin
            parity_next = parity_reg ^ (s2_vld_reg && flip);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            parity_reg <= 1'b0;
        end else begin
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s2_vld_next;
            parity_reg <= parity_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (vin.vld) begin
            prev_a_reg <= va;
            prev_b_reg <= vb;
        end
        s1_cross_reg <= s1_cross_next;
        s1_dypos_reg <= s1_dypos_next;
        s1_da_reg    <= s1_da_next;
        s1_dy_reg    <= s1_dy_next;
        s1_dx_reg    <= s1_dx_next;
        s1_db_reg    <= s1_db_next;
        s2_cross_reg <= s1_cross_reg;
        s2_dypos_reg <= s1_dypos_reg;
        s2_lhs_reg   <= s2_lhs_next;
        s2_rhs_reg   <= s2_rhs_next;
    end

    assign busy   = s1_vld_reg || s2_vld_reg;
    assign parity = parity_reg;

endmodule
`default_nettype wire

// ===== hdl/sector_point_locator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sector_point_locator: map of polygon sectors with point lookup
// Builds sectors from begin and add-vertex items and finds the first sector
// that holds a queried point; one result transfer per input transfer.
// ----------------------------------------------------------------------------
// Usage and flow: begin, add-vertex and unused items are decided in the
// accepting cycle and their result is registered into the output register as
// they are accepted. A locate walks the sectors in creation order out of the
// sector memory: a sector that fails the box or height check costs one memory
// read and one check, and for a sector with n vertices that passes them the
// crossing test streams the vertex memory through its single read port at one
// vertex per cycle (n + 1 reads with the wrap vertex) and then drains a
// three-stage multiply pipeline. A new item is taken once the controller is
// idle and the output register is free or being drained. No clearing pass
// after reset: only sectors already begun and their vertices are ever read.
// ----------------------------------------------------------------------------
module sector_point_locator #(
    parameter int SECTOR_SLOTS = 64,
    parameter int VERTEX_SLOTS = 1024,
    parameter int COORD_BITS   = 24
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pos_a[23:0], pos_b[47:24], query_height[71:48],
    // floor_height[87:72], ceil_height[103:88]
    input  logic [splc_pkg::IN_DATA_BITS-1:0]  s_tdata,
    // action[1:0]
    input  logic [splc_pkg::ACT_BITS-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // sector_index[5:0], zero fill [7:6]
    output logic [splc_pkg::OUT_DATA_BITS-1:0] m_tdata,
    // status[1:0], found[2]
    output logic [splc_pkg::OUT_USER_BITS-1:0] m_tuser
);
    import splc_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int VC = $clog2(VERTEX_SLOTS + 1);
    localparam int VA = $clog2(VERTEX_SLOTS);
    localparam int SC = $clog2(SECTOR_SLOTS + 1);
    localparam int SA = (SECTOR_SLOTS > 1) ? $clog2(SECTOR_SLOTS) : 1;

    typedef struct packed {
        logic [VC-1:0]       first;
        logic [VC-1:0]       cnt;
        logic signed [15:0]  flo;
        logic signed [15:0]  cei;
        logic signed [C-1:0] min_a;
        logic signed [C-1:0] max_a;
        logic signed [C-1:0] min_b;
        logic signed [C-1:0] max_b;
    } rec_t;

    // memories
    rec_t         sec_mem [SECTOR_SLOTS];
    logic [2*C-1:0] vtx_mem [VERTEX_SLOTS];

    rec_t           sec_rd_reg;
    logic [2*C-1:0] vtx_rd_reg;
    logic           sec_we, vtx_we;
    logic [SA-1:0]  sec_wa, sec_ra;
    logic [VA-1:0]  vtx_wa, vtx_ra;
    logic [2*C-1:0] vtx_wd;

    // control and working registers
    state_t         state_reg, state_next;
    logic [SC-1:0]  count_reg, count_next;
    rec_t           open_reg, open_next;     // write-through copy of the open sector
    logic signed [C-1:0] qa_reg, qa_next, qb_reg, qb_next, qh_reg, qh_next;
    logic [SC-1:0]  sidx_reg, sidx_next;
    logic [VC-1:0]  vptr_reg, vptr_next;
    logic [VC-1:0]  vrem_reg, vrem_next;
    logic           hit_reg, hit_next;
    vtx_ctl_t       rd_ctl_reg, rd_ctl_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [STATUS_BITS-1:0] m_status_reg, m_status_next;
    logic                  m_found_reg, m_found_next;
    logic [INDEX_BITS-1:0] m_index_reg, m_index_next;

    // decode
    logic                accept, out_free;
    act_t                act;
    logic signed [C-1:0] in_a, in_b, in_h;
    logic [SC-1:0]       cnt_m1;
    logic [VC-1:0]       slot, last_vtx;
    logic signed [31:0]  qh_w, flo_w, cei_w;
    logic                box_ok, hgt_ok, sec_pass;
    logic                drained, sidx_end;
    logic                edge_clear, edge_busy, edge_parity;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign act  = act_t'(s_tuser);
    assign in_a = C'(s_tdata[POS_A_LSB +: FIELD_BITS]);
    assign in_b = C'(s_tdata[POS_B_LSB +: FIELD_BITS]);
    assign in_h = C'(s_tdata[QH_LSB +: FIELD_BITS]);

    assign cnt_m1   = count_reg - 1'b1;
    assign slot     = open_reg.first + open_reg.cnt;
    assign last_vtx = sec_rd_reg.first + sec_rd_reg.cnt - 1'b1;
    assign sidx_end = (sidx_reg == count_reg);

    // sector check on the registered sector record
    always_comb begin
        qh_w   = 32'(qh_reg);
        flo_w  = 32'($signed(sec_rd_reg.flo));
        cei_w  = 32'($signed(sec_rd_reg.cei));
        box_ok = !(qa_reg < $signed(sec_rd_reg.min_a) || qa_reg > $signed(sec_rd_reg.max_a) ||
                   qb_reg < $signed(sec_rd_reg.min_b) || qb_reg > $signed(sec_rd_reg.max_b));
        hgt_ok = (qh_w >= flo_w) && (qh_w <= cei_w);
        // an empty sector never passes
        sec_pass = (sec_rd_reg.cnt != '0) && box_ok && hgt_ok;
    end

    assign drained = !rd_ctl_reg.vld && !edge_busy;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && act == ACT_LOCATE) state_next = ST_SREQ;
            end
            ST_SREQ: begin
                state_next = sidx_end ? ST_DONE : ST_SCHK;
            end
            ST_SCHK: begin
                state_next = sec_pass ? ST_VRUN : ST_SREQ;
            end
            ST_VRUN: begin
                if (vrem_reg == VC'(1)) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (drained) state_next = edge_parity ? ST_DONE : ST_SREQ;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        count_next  = count_reg;
        open_next   = open_reg;
        qa_next     = qa_reg;
        qb_next     = qb_reg;
        qh_next     = qh_reg;
        sidx_next   = sidx_reg;
        vptr_next   = vptr_reg;
        vrem_next   = vrem_reg;
        hit_next    = hit_reg;
        rd_ctl_next = '0;
        edge_clear  = 1'b0;
        sec_we      = 1'b0;
        sec_wa      = cnt_m1[SA-1:0];
        sec_ra      = sidx_reg[SA-1:0];
        vtx_we      = 1'b0;
        vtx_wa      = slot[VA-1:0];
        vtx_wd      = {in_b, in_a};
        vtx_ra      = vptr_reg[VA-1:0];

        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_found_next  = m_found_reg;
        m_index_next  = m_index_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    m_tvalid_next = (act != ACT_LOCATE);
                    m_status_next = STS_OK;
                    m_found_next  = 1'b0;
                    m_index_next  = '0;
                    unique case (act)
                        ACT_BEGIN: begin
                            if (count_reg == SC'(SECTOR_SLOTS)) begin
                                m_status_next = STS_SECTOR_FULL;
                            end else begin
                                open_next.first = (count_reg == '0) ? '0 : slot;
                                open_next.cnt   = '0;
                                open_next.flo   = s_tdata[FLOOR_LSB +: HGT_BITS];
                                open_next.cei   = s_tdata[CEIL_LSB +: HGT_BITS];
                                sec_we          = 1'b1;
                                sec_wa          = count_reg[SA-1:0];
                                count_next      = count_reg + 1'b1;
                                m_index_next    = INDEX_BITS'(count_reg);
                            end
                        end
                        ACT_ADD: begin
                            if (count_reg == '0) begin
                                m_status_next = STS_NO_SECTOR;
                            end else begin
                                m_index_next = INDEX_BITS'(cnt_m1);
                                if (slot == VC'(VERTEX_SLOTS)) begin
                                    m_status_next = STS_VERTEX_FULL;
                                end else begin
                                    vtx_we = 1'b1;
                                    // first vertex seeds the box
                                    if (open_reg.cnt == '0 || in_a < open_reg.min_a)
                                        open_next.min_a = in_a;
                                    if (open_reg.cnt == '0 || in_a > open_reg.max_a)
                                        open_next.max_a = in_a;
                                    if (open_reg.cnt == '0 || in_b < open_reg.min_b)
                                        open_next.min_b = in_b;
                                    if (open_reg.cnt == '0 || in_b > open_reg.max_b)
                                        open_next.max_b = in_b;
                                    open_next.cnt = open_reg.cnt + 1'b1;
                                    sec_we        = 1'b1;
                                end
                            end
                        end
                        ACT_LOCATE: begin
                            qa_next   = in_a;
                            qb_next   = in_b;
                            qh_next   = in_h;
                            sidx_next = '0;
                            hit_next  = 1'b0;
                        end
                        ACT_NOP: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SREQ: begin
                sec_ra = sidx_reg[SA-1:0];
            end
            ST_SCHK: begin
                if (sec_pass) begin
                    // wrap vertex first, then the walls in order
                    edge_clear  = 1'b1;
                    vtx_ra      = last_vtx[VA-1:0];
                    rd_ctl_next = '{vld: 1'b1, first: 1'b1};
                    vptr_next   = sec_rd_reg.first;
                    vrem_next   = sec_rd_reg.cnt;
                end else begin
                    sidx_next = sidx_reg + 1'b1;
                end
            end
            ST_VRUN: begin
                vtx_ra      = vptr_reg[VA-1:0];
                rd_ctl_next = '{vld: 1'b1, first: 1'b0};
                vptr_next   = vptr_reg + 1'b1;
                vrem_next   = vrem_reg - 1'b1;
            end
            ST_DRAIN: begin
                if (drained) begin
                    if (edge_parity) hit_next = 1'b1;
                    else sidx_next = sidx_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = STS_OK;
                    m_found_next  = hit_reg;
                    m_index_next  = hit_reg ? INDEX_BITS'(sidx_reg) : '0;
                end
            end
            default: begin
            end
        endcase
    end

    // sector record memory
    always_ff @(posedge aclk) begin
        if (sec_we) sec_mem[sec_wa] <= open_next;
        sec_rd_reg <= sec_mem[sec_ra];
    end

    // vertex memory
    always_ff @(posedge aclk) begin
        if (vtx_we) vtx_mem[vtx_wa] <= vtx_wd;
        vtx_rd_reg <= vtx_mem[vtx_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            rd_ctl_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_ctl_reg   <= rd_ctl_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        open_reg     <= open_next;
        qa_reg       <= qa_next;
        qb_reg       <= qb_next;
        qh_reg       <= qh_next;
        sidx_reg     <= sidx_next;
        vptr_reg     <= vptr_next;
        vrem_reg     <= vrem_next;
        hit_reg      <= hit_next;
        m_status_reg <= m_status_next;
        m_found_reg  <= m_found_next;
        m_index_reg  <= m_index_next;
    end

    splc_edge #(
        .COORD_BITS(COORD_BITS)
    ) u_edge (
        .aclk   (aclk),
        .aresetn(aresetn),
        .clear  (edge_clear),
        .vin    (rd_ctl_reg),
        .va     (vtx_rd_reg[C-1:0]),
        .vb     (vtx_rd_reg[2*C-1:C]),
        .qa     (qa_reg),
        .qb     (qb_reg),
        .busy   (edge_busy),
        .parity (edge_parity)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_DATA_BITS'(m_index_reg);
    assign m_tuser  = {m_found_reg, m_status_reg};

endmodule
`default_nettype wire

// ===== hdl/splc_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// splc_checker: port-level checks for the sector point locator
// Watches the result stream and its relation to reset and input transfers.
// ----------------------------------------------------------------------------
module splc_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [splc_pkg::OUT_DATA_BITS-1:0] m_tdata,
    input logic [splc_pkg::OUT_USER_BITS-1:0] m_tuser
);
    import splc_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed under stall");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a found sector always reports ok status
    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[FOUND_BIT] |-> m_tuser[STATUS_BITS-1:0] == STS_OK)
        else $error("found with error status");

    // table-full and no-sector results carry index zero
    a_err_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[STATUS_BITS-1:0] == STS_SECTOR_FULL ||
                     m_tuser[STATUS_BITS-1:0] == STS_NO_SECTOR) |-> m_tdata == '0)
        else $error("error result with nonzero index");

    // input is never taken while a stalled result is pending
    a_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !(s_tvalid && s_tready))
        else $error("input taken with result stalled");

endmodule

bind sector_point_locator splc_checker u_splc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
`default_nettype wire

// ===== dv/splc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// splc_scoreboard: result predictor and scoreboard for sector_point_locator
// Watches both stream channels, keeps its own sector map and vertex store,
// predicts one result per accepted input transfer and compares in order.
// ----------------------------------------------------------------------------
module splc_scoreboard (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [splc_pkg::IN_DATA_BITS-1:0]  s_tdata,
    input  logic [splc_pkg::ACT_BITS-1:0]      s_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [splc_pkg::OUT_DATA_BITS-1:0] m_tdata,
    input  logic [splc_pkg::OUT_USER_BITS-1:0] m_tuser,
    output int                                 errors,
    output int                                 pending
);
    import splc_pkg::*;

    localparam int NSEC = 64;
    localparam int NVTX = 1024;

    typedef struct packed {
        status_t        status;
        logic           found;
        logic [5:0]     index;
    } lookup_result_t;

    lookup_result_t result_q[$];

    int unsigned sec_total;
    int unsigned sec_first[NSEC];
    int unsigned sec_nvtx[NSEC];
    int          sec_floor[NSEC];
    int          sec_ceil[NSEC];
    int          min_a[NSEC], max_a[NSEC], min_b[NSEC], max_b[NSEC];
    int          vtx_a[NVTX], vtx_b[NVTX];

    // even-odd crossing test with exact cross-multiplied compare
    function automatic bit point_in_sector(int unsigned s, longint pa, longint pb);
        int unsigned n, cur, prv;
        longint ax, ay, bx, by, dy, lhs, rhs;
        bit in;
        n = sec_nvtx[s];
        in = 1'b0;
        if (pa < min_a[s] || pa > max_a[s] || pb < min_b[s] || pb > max_b[s])
            return 1'b0;
        for (int unsigned i = 0; i < n; i++) begin
            cur = sec_first[s] + i;
            prv = sec_first[s] + ((i == 0) ? n - 1 : i - 1);
            if (cur >= NVTX || prv >= NVTX)
                break;
            ax = vtx_a[cur]; ay = vtx_b[cur];
            bx = vtx_a[prv]; by = vtx_b[prv];
            if ((ay > pb) == (by > pb))
                continue;
            dy  = by - ay;
            lhs = (pa - ax) * dy;
            rhs = (bx - ax) * (pb - ay);
            if (dy > 0 ? (lhs < rhs) : (lhs > rhs))
                in = !in;
        end
        return in;
    endfunction

    function automatic lookup_result_t apply_item(act_t act, logic [IN_DATA_BITS-1:0] d);
        lookup_result_t r;
        longint pa, pb, qh;
        int unsigned s, slot;
        int a, b;
        pa = longint'($signed(d[POS_A_LSB +: FIELD_BITS]));
        pb = longint'($signed(d[POS_B_LSB +: FIELD_BITS]));
        qh = longint'($signed(d[QH_LSB +: FIELD_BITS]));
        r = '{status: STS_OK, found: 1'b0, index: '0};
        case (act)
            ACT_BEGIN: begin
                if (sec_total >= NSEC) begin
                    r.status = STS_SECTOR_FULL;
                end else begin
                    s = sec_total;
                    sec_first[s] = (s == 0) ? 0 : sec_first[s-1] + sec_nvtx[s-1];
                    sec_nvtx[s]  = 0;
                    sec_floor[s] = int'($signed(d[FLOOR_LSB +: HGT_BITS]));
                    sec_ceil[s]  = int'($signed(d[CEIL_LSB +: HGT_BITS]));
                    min_a[s] = 32'h7fffffff; max_a[s] = 32'h80000000;
                    min_b[s] = 32'h7fffffff; max_b[s] = 32'h80000000;
                    sec_total = s + 1;
                    r.index = s[5:0];
                end
            end
            ACT_ADD: begin
                if (sec_total == 0) begin
                    r.status = STS_NO_SECTOR;
                end else begin
                    s = sec_total - 1;
                    slot = sec_first[s] + sec_nvtx[s];
                    r.index = s[5:0];
                    if (slot >= NVTX) begin
                        r.status = STS_VERTEX_FULL;
                    end else begin
                        a = int'(pa); b = int'(pb);
                        vtx_a[slot] = a; vtx_b[slot] = b;
                        if (a < min_a[s]) min_a[s] = a;
                        if (a > max_a[s]) max_a[s] = a;
                        if (b < min_b[s]) min_b[s] = b;
                        if (b > max_b[s]) max_b[s] = b;
                        sec_nvtx[s]++;
                    end
                end
            end
            ACT_LOCATE: begin
                for (int unsigned i = 0; i < sec_total; i++) begin
                    if (point_in_sector(i, pa, pb) && qh >= sec_floor[i] &&
                        qh <= sec_ceil[i]) begin
                        r.found = 1'b1;
                        r.index = i[5:0];
                        break;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    assign pending = result_q.size();

    always @(posedge aclk) begin
        lookup_result_t want, got;
        if (!aresetn) begin
            sec_total = 0;
            result_q.delete();
            errors <= 0;
        end else begin
            if (s_tvalid && s_tready)
                result_q.push_back(apply_item(act_t'(s_tuser), s_tdata));
            if (m_tvalid && m_tready) begin
                got = '{status: status_t'(m_tuser[STATUS_BITS-1:0]),
                        found: m_tuser[FOUND_BIT], index: m_tdata[INDEX_BITS-1:0]};
                if (result_q.size() == 0) begin
                    if (errors < 10)
                        $display("%0t: result transfer with nothing expected: sts=%0d found=%0b idx=%0d",
                                 $realtime, got.status, got.found, got.index);
                    errors <= errors + 1;
                end else begin
                    want = result_q.pop_front();
                    if (got != want) begin
                        if (errors < 10)
                            $display("%0t: mismatch exp sts=%0d found=%0b idx=%0d, got sts=%0d found=%0b idx=%0d",
                                     $realtime, want.status, want.found, want.index,
                                     got.status, got.found, got.index);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for sector_point_locator
// Builds polygon maps with random stalls on both channels, probes them with
// locate transfers near sector boxes, drives the sector table to overflow;
// the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import splc_pkg::*;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata;   // pos_a, pos_b, query_height, floor, ceil
    logic [ACT_BITS-1:0]      s_tuser;   // action
    logic                     m_tvalid;
    logic                     m_tready;
    logic [OUT_DATA_BITS-1:0] m_tdata;   // sector_index, zero fill
    logic [OUT_USER_BITS-1:0] m_tuser;   // status, found
    int                       errors;
    int                       pending;

    // stimulus-side view of the map, only used to aim locates
    int  sectors_made;
    int  items_sent;
    int  ctr_a[64], ctr_b[64], span[64], flo[64], cei[64];
    bit  hold_req;

    sector_point_locator DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    splc_scoreboard u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .errors(errors), .pending(pending)
    );

    always begin
        aclk = 1'b0; #5;
        aclk = 1'b1; #5;
    end

    // run limit, far beyond the slowest legal run
    initial begin
        #50ms;
        $display("CHECK FAILED");
        $finish;
    end

    // mostly short idle gaps, now and then a long one
    function automatic int idle_len();
        int k;
        k = $urandom_range(0, 9);
        if (k < 5) return 0;
        if (k < 9) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    // offer one transfer and hold it until accepted; valid stays high
    // into the next transfer unless a gap follows
    task automatic send(act_t act, logic [23:0] pa, logic [23:0] pb, logic [23:0] qh,
                        logic [15:0] fl, logic [15:0] cl);
        int gap;
        s_tuser  <= act;
        s_tdata  <= {cl, fl, qh, pb, pa};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic begin_sector(int ca, int cb, int sp, logic [15:0] fl, logic [15:0] cl);
        if (sectors_made < 64) begin
            ctr_a[sectors_made] = ca; ctr_b[sectors_made] = cb; span[sectors_made] = sp;
            flo[sectors_made] = $signed(fl); cei[sectors_made] = $signed(cl);
            sectors_made++;
        end
        send(ACT_BEGIN, $urandom, $urandom, $urandom, fl, cl);
    endtask

    task automatic add_vertex(logic [23:0] pa, logic [23:0] pb);
        send(ACT_ADD, pa, pb, $urandom, $urandom, $urandom);
    endtask

    // locate aimed at a made sector, or anywhere when none exists and now and then at random
    task automatic probe();
        int s, qh, lo, hi;
        if (sectors_made == 0 || $urandom_range(0, 9) == 0) begin
            send(ACT_LOCATE, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            s  = $urandom_range(0, sectors_made - 1);
            lo = (flo[s] < cei[s]) ? flo[s] : cei[s];
            hi = (flo[s] < cei[s]) ? cei[s] : flo[s];
            case ($urandom_range(0, 3))
                0:       qh = lo;
                1:       qh = hi;
                2:       qh = lo - 1 + $urandom_range(0, 1) * (hi - lo + 2);
                default: qh = $urandom_range(0, hi - lo) + lo;
            endcase
            send(ACT_LOCATE, ctr_a[s] + $urandom_range(0, 2 * span[s]) - span[s],
                 ctr_b[s] + $urandom_range(0, 2 * span[s]) - span[s], qh,
                 $urandom, $urandom);
        end
    endtask

    // a new sector with a random polygon around a random center
    task automatic random_sector();
        int ca, cb, sp, nv;
        logic [15:0] fl, cl;
        sp = ($urandom_range(0, 7) == 0) ? $urandom_range(1000, 300000) : $urandom_range(1, 60);
        ca = $urandom_range(0, 16000000) - 8000000;
        cb = $urandom_range(0, 16000000) - 8000000;
        if ($urandom_range(0, 3) == 0) begin
            ca = $urandom_range(0, 200) - 100;   // overlapping sectors near the origin
            cb = $urandom_range(0, 200) - 100;
        end
        fl = $urandom;
        cl = $urandom;
        if ($urandom_range(0, 4) != 0 && $signed(fl) > $signed(cl)) {fl, cl} = {cl, fl};
        begin_sector(ca, cb, sp, fl, cl);
        nv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
        repeat (nv)
            add_vertex(ca + $urandom_range(0, 2 * sp) - sp, cb + $urandom_range(0, 2 * sp) - sp);
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin
        int k;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (600) @(posedge aclk);
            end else begin
                k = $urandom_range(0, 9);
                if (k < 5) begin
                    m_tready <= 1'b1;
                    repeat ($urandom_range(1, (k == 0) ? 200 : 30)) @(posedge aclk);
                end else if (k < 9) begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge aclk);
                end else begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(20, 120)) @(posedge aclk);
                end
            end
        end
    end

    initial begin
        localparam logic [23:0] CMIN = 24'h800000;
        localparam logic [23:0] CMAX = 24'h7fffff;
        localparam logic [15:0] HMIN = 16'h8000;
        localparam logic [15:0] HMAX = 16'h7fff;
        int k;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= ACT_NOP;
        hold_req = 1'b0;
        sectors_made = 0; items_sent = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: add with no sector open, unused action, empty-map locate
        add_vertex(CMIN, CMAX);
        send(ACT_NOP, CMAX, CMIN, CMAX, HMAX, HMIN);
        send(ACT_LOCATE, 24'd0, 24'd0, 24'd0, '0, '0);
        // empty sector first, then a full-range square with widest heights
        begin_sector(0, 0, 0, 16'd0, 16'd0);
        send(ACT_LOCATE, 24'd0, 24'd0, 24'd0, '0, '0);
        begin_sector(0, 0, 8000000, HMIN, HMAX);
        add_vertex(CMIN, CMIN);
        add_vertex(CMAX, CMIN);
        add_vertex(CMAX, CMAX);
        add_vertex(CMIN, CMAX);
        send(ACT_LOCATE, 24'd0, 24'd0, 24'd0, '0, '0);
        send(ACT_LOCATE, CMIN, CMIN, {{8{1'b1}}, HMIN}, '0, '0);
        send(ACT_LOCATE, CMAX, CMAX, {8'd0, HMAX}, '0, '0);
        send(ACT_LOCATE, 24'd5, 24'd7, CMIN, '0, '0);
        send(ACT_LOCATE, 24'd5, 24'd7, 24'd32768, '0, '0);
        send(ACT_LOCATE, 24'd5, 24'd7, CMAX, '0, '0);
        // inverted heights: the box passes for both probes and the crossing for the first, height never does
        begin_sector(10, 10, 5, 16'd10, 16'd5);
        add_vertex(24'd0, 24'd0);
        add_vertex(24'd20, 24'd0);
        add_vertex(24'd10, 24'd20);
        send(ACT_LOCATE, 24'd10, 24'd5, 24'd7, '0, '0);
        send(ACT_LOCATE, 24'd10, 24'd20, 24'd0, '0, '0);

        // sender pauses until every result is back
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);

        // random: mostly sector builds with probes, some noise
        hold_req = 1'b1;
        while (items_sent < 480) begin
            k = $urandom_range(0, 19);
            if (k < 9 && sectors_made < 64)
                random_sector();
            else if (k < 17)
                probe();
            else if (k < 18)
                send(ACT_BEGIN, $urandom, $urandom, $urandom, $urandom, $urandom);
            else
                send(act_t'($urandom_range(1, 3)), $urandom, $urandom, $urandom,
                     $urandom, $urandom);
        end

        // fill the sector table and overflow it
        while (sectors_made < 64) random_sector();
        repeat (3) send(ACT_BEGIN, $urandom, $urandom, $urandom, $urandom, $urandom);
        repeat (10) probe();

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
